// ----- hw/rtl/ggpc_pkg.sv -----
// Package for the go-to-goal proportional controller.
// Holds widths, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
package ggpc_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_GAIN = 2'd3;

    localparam logic signed [15:0] GOAL_X_RST       = 16'sd768;
    localparam logic signed [15:0] GOAL_Y_RST       = 16'sd768;
    localparam logic [15:0]        LINEAR_GAIN_RST  = 16'd3686;
    localparam logic [15:0]        ANGULAR_GAIN_RST = 16'd2458;

    localparam logic signed [15:0] PI_Q12          = 16'sd12868;
    localparam logic signed [15:0] TWO_PI_Q12      = 16'sd25736;
    localparam logic signed [19:0] HALF_PI_Q16     = 20'sd102944;
    localparam logic [34:0]        NEAR_SQ_Q16     = 35'd656;
    localparam logic signed [16:0] ANGLE_LIMIT_Q12 = 17'sd3686;
    localparam logic [8:0]         SPEED_CAP_Q8    = 9'd384;

    localparam logic OP_POSE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    function automatic logic [16:0] atan_q16(input logic [4:0] idx);
        logic [16:0] v;
        begin
            case (idx)
                5'd0:  v = 17'd51472;
                5'd1:  v = 17'd30386;
                5'd2:  v = 17'd16055;
                5'd3:  v = 17'd8150;
                5'd4:  v = 17'd4091;
                5'd5:  v = 17'd2047;
                5'd6:  v = 17'd1024;
                5'd7:  v = 17'd512;
                5'd8:  v = 17'd256;
                5'd9:  v = 17'd128;
                5'd10: v = 17'd64;
                5'd11: v = 17'd32;
                5'd12: v = 17'd16;
                5'd13: v = 17'd8;
                5'd14: v = 17'd4;
                5'd15: v = 17'd2;
                5'd16: v = 17'd1;
                5'd17: v = 17'd1;
                default: v = 17'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- hw/rtl/go_to_goal_proportional_controller.sv -----
// Top level of the go-to-goal proportional controller.
// Uses ggpc_pkg for constants and the arctangent table; no submodules.
// Sequencer with one shared add/shift datapath plus one 18x18 multiplier.

// A pose transfer (op = 0) stores position and heading in the cycle it is accepted, gives
// no result, and the block stays ready. A control tick (op = 1) computes the squared
// distance to the goal from the squares of dx and dy, then runs a bit-serial square root
// (one result bit per cycle), a vectoring CORDIC of min(CORDIC_STEPS, ATAN_ENTRIES)
// iterations (one per cycle), and the states for rounding, heading wrap, gain multiplies
// and output. The serial square root and the CORDIC loop share the sequencer. While busy,
// s_axis_tready is low. A tick close to the goal gives one zero command with reached set;
// after that, ticks give no result until reset. The result sits in an output register
// until taken, and a new item may be accepted while it waits, but a tick is only started
// when the output register is free; until then it waits in ST_DIFF.
module go_to_goal_proportional_controller
    import ggpc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // bits 15:0 pos_x, 31:16 pos_y, 46:32 heading, 47 zero fill
    input  logic [47:0]           s_axis_tdata,
    // bit 0 op
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // bits 8:0 linear_speed, 24:9 angular_speed, 31:25 zero fill
    output logic [31:0]           m_axis_tdata,
    // bit 0 reached
    output logic                  m_axis_tuser
);

    localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int SQ_ITERS = 17;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_SQX, ST_SQY, ST_NEAR, ST_SQRT, ST_CORD,
        ST_ROUND, ST_WRAP, ST_MULA, ST_MULL, ST_OUT
    } state_t;

    state_t state_reg;
    logic signed [15:0] goal_x_reg, goal_y_reg;
    logic [15:0] lin_gain_reg, ang_gain_reg;
    logic signed [15:0] sx_reg, sy_reg;
    logic signed [14:0] sh_reg;
    logic latched_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic [34:0] s_reg, rem_reg;
    logic [17:0] root_reg;
    logic [4:0] it_reg;
    logic signed [27:0] cx_reg, cy_reg;
    logic signed [21:0] z_reg;
    logic signed [16:0] err_reg;
    logic m_valid_reg;
    logic [8:0] lin_reg;
    logic signed [15:0] ang_reg;
    logic reached_reg;

    // Shared multiplier: 18-bit signed operands.
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX: begin mul_a = 18'(dx_reg); mul_b = 18'(dx_reg); end
            ST_SQY: begin mul_a = 18'(dy_reg); mul_b = 18'(dy_reg); end
            ST_MULA: begin mul_a = $signed({2'b00, ang_gain_reg}); mul_b = 18'(err_reg); end
            ST_MULL: begin mul_a = $signed({2'b00, lin_gain_reg});
                           mul_b = $signed(root_reg); end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    logic signed [27:0] xs, ys;
    assign xs = cx_reg >>> it_reg;
    assign ys = cy_reg >>> it_reg;

    logic signed [22:0] zr;
    assign zr = (23'(z_reg) + 23'sd8) >>> 4;

    logic signed [17:0] err_raw;
    assign err_raw = 18'(z_reg) - 18'(sh_reg);

    logic signed [36:0] ang_full;
    assign ang_full = (37'(mul_p) + 37'sd32768) >>> 16;
    logic [36:0] lin_full;
    assign lin_full = (37'(mul_p) + 37'd2048) >> 12;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, ang_reg, lin_reg};
    assign m_axis_tuser  = reached_reg;

    // The squared distance stays below 2^34, so the root walks bit pairs 33:32 down to 1:0.
    logic [35:0] rem_ext;
    assign rem_ext = {rem_reg[33:0], s_reg[33:32]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            goal_x_reg   <= GOAL_X_RST;
            goal_y_reg   <= GOAL_Y_RST;
            lin_gain_reg <= LINEAR_GAIN_RST;
            ang_gain_reg <= ANGULAR_GAIN_RST;
            sx_reg       <= '0;
            sy_reg       <= '0;
            sh_reg       <= '0;
            latched_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_GOAL_X:       goal_x_reg   <= $signed(cfg_data);
                    CFG_GOAL_Y:       goal_y_reg   <= $signed(cfg_data);
                    CFG_LINEAR_GAIN:  lin_gain_reg <= cfg_data;
                    CFG_ANGULAR_GAIN: ang_gain_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_axis_tready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        if (s_axis_tuser == OP_POSE) begin
                            sx_reg <= $signed(s_axis_tdata[15:0]);
                            sy_reg <= $signed(s_axis_tdata[31:16]);
                            sh_reg <= $signed(s_axis_tdata[46:32]);
                        end else if (!latched_reg) begin
                            state_reg <= ST_DIFF;
                        end
                    end
                end
                ST_DIFF: begin
                    // The tick starts once the previous result has left the output register.
                    if (!m_valid_reg || m_axis_tready) begin
                        dx_reg <= 17'(goal_x_reg) - 17'(sx_reg);
                        dy_reg <= 17'(goal_y_reg) - 17'(sy_reg);
                        state_reg <= ST_SQX;
                    end
                end
                ST_SQX: begin
                    s_reg <= 35'(mul_p);
                    state_reg <= ST_SQY;
                end
                ST_SQY: begin
                    s_reg <= s_reg + 35'(mul_p);
                    state_reg <= ST_NEAR;
                end
                ST_NEAR: begin
                    if (s_reg < NEAR_SQ_Q16) begin
                        latched_reg <= 1'b1;
                        lin_reg     <= '0;
                        ang_reg     <= '0;
                        reached_reg <= 1'b1;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end else begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        it_reg    <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    // Consume the top two radicand bits each step.
                    if (rem_ext >= {root_reg[15:0], 2'b01} + 36'd0) begin
                        rem_reg  <= 35'(rem_ext - {18'd0, root_reg[15:0], 2'b01});
                        root_reg <= {root_reg[16:0], 1'b1};
                    end else begin
                        rem_reg  <= 35'(rem_ext);
                        root_reg <= {root_reg[16:0], 1'b0};
                    end
                    s_reg <= {s_reg[32:0], 2'b00};
                    if (it_reg == 5'(SQ_ITERS - 1)) begin
                        it_reg <= '0;
                        // Pre-rotate into the right half plane.
                        if (dx_reg < 0) begin
                            if (dy_reg >= 0) begin
                                cx_reg <= 28'(dy_reg) <<< 8;
                                cy_reg <= -(28'(dx_reg) <<< 8);
                                z_reg  <= 22'(HALF_PI_Q16);
                            end else begin
                                cx_reg <= -(28'(dy_reg) <<< 8);
                                cy_reg <= 28'(dx_reg) <<< 8;
                                z_reg  <= -22'(HALF_PI_Q16);
                            end
                        end else begin
                            cx_reg <= 28'(dx_reg) <<< 8;
                            cy_reg <= 28'(dy_reg) <<< 8;
                            z_reg  <= '0;
                        end
                        state_reg <= (NSTEPS == 0) ? ST_ROUND : ST_CORD;
                    end else begin
                        it_reg <= it_reg + 5'd1;
                    end
                end
                ST_CORD: begin
                    if (cy_reg >= 0) begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        z_reg  <= z_reg + 22'(atan_q16(it_reg));
                    end else begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        z_reg  <= z_reg - 22'(atan_q16(it_reg));
                    end
                    if (it_reg == 5'(NSTEPS - 1)) state_reg <= ST_ROUND;
                    else it_reg <= it_reg + 5'd1;
                end
                ST_ROUND: begin
                    if (zr > 23'(PI_Q12)) z_reg <= 22'(PI_Q12);
                    else if (zr < -23'(PI_Q12)) z_reg <= -22'(PI_Q12);
                    else z_reg <= 22'(zr);
                    state_reg <= ST_WRAP;
                end
                ST_WRAP: begin
                    if (err_raw > 18'(PI_Q12)) err_reg <= 17'(err_raw - 18'(TWO_PI_Q12));
                    else if (err_raw < -18'(PI_Q12))
                        err_reg <= 17'(err_raw + 18'(TWO_PI_Q12));
                    else err_reg <= 17'(err_raw);
                    state_reg <= ST_MULA;
                end
                ST_MULA: begin
                    if (ang_full > 37'sd32767) ang_reg <= 16'sd32767;
                    else if (ang_full < -37'sd32768) ang_reg <= -16'sd32768;
                    else ang_reg <= 16'(ang_full);
                    state_reg <= ST_MULL;
                end
                ST_MULL: begin
                    if (err_reg > ANGLE_LIMIT_Q12 || err_reg < -ANGLE_LIMIT_Q12)
                        lin_reg <= '0;
                    else if (lin_full > 37'(SPEED_CAP_Q8)) lin_reg <= SPEED_CAP_Q8;
                    else lin_reg <= 9'(lin_full);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    reached_reg <= 1'b0;
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    logic unused_ok;
    assign unused_ok = s_axis_tdata[47];

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_latch_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        latched_reg |=> latched_reg)
        else $error("latch cleared");
    a_reached_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("reached with nonzero command");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the go-to-goal proportional controller.
// Drives pose and tick transfers, predicts each command in a local model and compares.
// Depends on ggpc_pkg and go_to_goal_proportional_controller.
`timescale 1ns / 1ps

module tb;
    import ggpc_pkg::*;

    typedef struct packed {
        logic               op;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [14:0] heading;
    } pose_item_t;

    typedef struct packed {
        logic [8:0]         linear_speed;
        logic signed [15:0] angular_speed;
        logic               reached;
    } command_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    go_to_goal_proportional_controller i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // Predictor state: a private copy of the block's registers and pose.
    logic signed [15:0] goal_x_q, goal_y_q;
    logic [15:0]        lin_gain_q, ang_gain_q;
    logic signed [15:0] pose_x_q, pose_y_q, pose_hdg_q;
    logic               arrived_q;

    pose_item_t pending_items[$];
    command_t   expected_cmds[$];
    bit         failed;
    bit         throttle_on;
    int         quiet_cycles;

    localparam int WATCHDOG_LIMIT = 20000;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Floor square root by bit pairs.
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int atan_step(input int k);
        int steps[18] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
                          64, 32, 16, 8, 4, 2, 1, 1};
        return (k < 18) ? steps[k] : 0;
    endfunction

    // Vectoring CORDIC bearing in Q3.12, with the quarter-turn pre-rotation.
    function automatic longint goal_bearing(input longint dx, input longint dy);
        longint x, y, z, t, xs, ys;
        int k;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 102944;
            end else begin
                t = x; x = -y; y = t; z = -102944;
            end
        end
        for (k = 0; k < 16; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(atan_step(k));
            end else begin
                x -= ys; y += xs; z -= longint'(atan_step(k));
            end
        end
        z = (z + 8) >>> 4;
        if (z > 12868) z = 12868;
        if (z < -12868) z = -12868;
        return z;
    endfunction

    // Applies one accepted item to the predictor and queues any command it causes.
    task automatic predict_command(input pose_item_t it);
        longint dx, dy, err, ang, lin;
        longint unsigned sq, dist_q8;
        command_t c;
        if (it.op == OP_POSE) begin
            pose_x_q = it.pos_x;
            pose_y_q = it.pos_y;
            pose_hdg_q = 16'(it.heading);
        end else if (!arrived_q) begin
            dx = longint'(goal_x_q) - pose_x_q;
            dy = longint'(goal_y_q) - pose_y_q;
            sq = dx * dx + dy * dy;
            if (sq < 656) begin
                arrived_q = 1'b1;
                c = '{9'd0, 16'sd0, 1'b1};
            end else begin
                dist_q8 = floor_sqrt(sq);
                err = goal_bearing(dx, dy) - pose_hdg_q;
                if (err > 12868) err -= 25736;
                else if (err < -12868) err += 25736;
                ang = (longint'(ang_gain_q) * err + 32768) >>> 16;
                if (ang > 32767) ang = 32767;
                if (ang < -32768) ang = -32768;
                lin = 0;
                if (err <= 3686 && err >= -3686) begin
                    lin = (longint'(lin_gain_q) * longint'(dist_q8) + 2048) >>> 12;
                    if (lin > 384) lin = 384;
                end
                c = '{9'(lin), 16'(ang), 1'b0};
            end
            expected_cmds.push_back(c);
        end
    endtask

    // Driver: presents the oldest pending item; idles at random while throttled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                predict_command(pending_items.pop_front());
            end
            if (pending_items.size() > 0 &&
                    (!throttle_on || $urandom_range(99) >= 37)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_items[0].op;
                s_axis_tdata <= {1'b0, pending_items[0].heading,
                                 pending_items[0].pos_y, pending_items[0].pos_x};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks every command transfer against the oldest prediction.
    always @(posedge aclk) begin
        command_t got, want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            m_axis_tready <= !throttle_on || ($urandom_range(99) >= 37);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[8:0], m_axis_tdata[24:9], m_axis_tuser};
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected command, expected none, actual %h", $time, got);
                    failed = 1'b1;
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.linear_speed !== want.linear_speed ||
                            got.angular_speed !== want.angular_speed ||
                            got.reached !== want.reached || m_axis_tdata[31:25] !== 7'd0) begin
                        $display("%0t: command mismatch, expected lin %0d ang %0d reached %0b, actual lin %0d ang %0d reached %0b",
                                 $time, want.linear_speed, want.angular_speed, want.reached,
                                 got.linear_speed, got.angular_speed, got.reached);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge aclk) begin
        if (aresetn && quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_GOAL_X:       goal_x_q = val;
            CFG_GOAL_Y:       goal_y_q = val;
            CFG_LINEAR_GAIN:  lin_gain_q = val;
            CFG_ANGULAR_GAIN: ang_gain_q = val;
            default: ;
        endcase
    endtask

    // Waits until every queued item was taken and every command came back,
    // then lets a tick that causes no command finish inside the block.
    task automatic drain;
        while (pending_items.size() > 0 || s_axis_tvalid || expected_cmds.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic pose_item_t make_pose(input logic signed [15:0] x,
                                             input logic signed [15:0] y,
                                             input logic signed [14:0] h);
        return '{OP_POSE, x, y, h};
    endfunction

    function automatic pose_item_t make_tick();
        return '{OP_TICK, 16'(signed'($urandom)), 16'(signed'($urandom)),
                 15'(signed'($urandom))};
    endfunction

    function automatic logic signed [14:0] rand_heading();
        return 15'(signed'($urandom_range(25736)) - 12868);
    endfunction

    // Queues a pose near the goal most of the time, so that both heading regimes are hit.
    // The pose is kept outside the stop radius so that the latch is only set on purpose.
    task automatic queue_random_pair(input int spread);
        logic signed [15:0] x, y;
        longint ddx, ddy;
        do begin
            if ($urandom_range(9) == 0) begin
                x = 16'($urandom);
                y = 16'($urandom);
            end else begin
                x = 16'(goal_x_q + $signed($urandom_range(2 * spread)) - spread);
                y = 16'(goal_y_q + $signed($urandom_range(2 * spread)) - spread);
            end
            ddx = longint'(goal_x_q) - x;
            ddy = longint'(goal_y_q) - y;
        end while (ddx * ddx + ddy * ddy < 656);
        pending_items.push_back(make_pose(x, y, rand_heading()));
        pending_items.push_back(make_tick());
    endtask

    initial begin
        int n;
        int phase;
        failed = 1'b0;
        throttle_on = 1'b1;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_GOAL_X;
        cfg_data = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_POSE;
        m_axis_tready = 1'b0;
        goal_x_q = GOAL_X_RST;
        goal_y_q = GOAL_Y_RST;
        lin_gain_q = LINEAR_GAIN_RST;
        ang_gain_q = ANGULAR_GAIN_RST;
        pose_x_q = 0;
        pose_y_q = 0;
        pose_hdg_q = 0;
        arrived_q = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: tick from the reset pose, field extremes, heading wrap on both sides,
        // large error that blocks forward speed, speed cap, and the largest gains.
        pending_items.push_back(make_tick());
        pending_items.push_back(make_pose(16'sh8000, 16'sh7fff, 15'sd12868));
        pending_items.push_back(make_tick());
        pending_items.push_back(make_pose(16'sh7fff, 16'sh8000, -15'sd12868));
        pending_items.push_back(make_tick());
        pending_items.push_back(make_pose(16'sd768, 16'sd0, 15'sd12000));
        pending_items.push_back(make_tick());
        pending_items.push_back(make_pose(16'sd768, 16'sd1536, -15'sd12000));
        pending_items.push_back(make_tick());
        pending_items.push_back(make_pose(16'sd0, 16'sd768, 15'sd0));
        pending_items.push_back(make_tick());
        pending_items.push_back(make_pose(16'sd1536, 16'sd768, 15'sd0));
        pending_items.push_back(make_tick());
        pending_items.push_back(make_pose(16'sh7fff, 16'sh7fff, 15'sh3fff));
        pending_items.push_back(make_tick());
        drain();
        write_reg(CFG_ANGULAR_GAIN, 16'hffff);
        write_reg(CFG_LINEAR_GAIN, 16'hffff);
        pending_items.push_back(make_pose(16'sd0, 16'sd768, 15'sd12868));
        pending_items.push_back(make_tick());
        pending_items.push_back(make_pose(16'sh8000, 16'sh8000, -15'sd12868));
        pending_items.push_back(make_tick());
        drain();
        write_reg(CFG_ANGULAR_GAIN, 16'h0000);
        write_reg(CFG_LINEAR_GAIN, 16'h0000);
        write_reg(CFG_GOAL_X, 16'sh8000);
        write_reg(CFG_GOAL_Y, 16'sh7fff);
        pending_items.push_back(make_pose(16'sh7fff, 16'sh8000, 15'sd5));
        pending_items.push_back(make_tick());
        drain();

        // Random phases under different gain and goal settings; each phase has many
        // poses that wander around the goal. The goal-reached latch is hit last.
        for (phase = 0; phase < 4; phase++) begin
            throttle_on = (phase != 2);
            write_reg(CFG_GOAL_X, 16'($urandom));
            write_reg(CFG_GOAL_Y, 16'($urandom));
            write_reg(CFG_LINEAR_GAIN, (phase == 0) ? LINEAR_GAIN_RST : 16'($urandom));
            write_reg(CFG_ANGULAR_GAIN, (phase == 0) ? ANGULAR_GAIN_RST : 16'($urandom));
            for (n = 0; n < 58; n++) begin
                queue_random_pair((n % 3 == 0) ? 40 : 2000);
                if ($urandom_range(7) == 0) pending_items.push_back(make_tick());
            end
            drain();
        end

        // Goal reached: one zero command, then silence; poses and new goals keep it latched.
        throttle_on = 1'b1;
        write_reg(CFG_GOAL_X, GOAL_X_RST);
        write_reg(CFG_GOAL_Y, GOAL_Y_RST);
        pending_items.push_back(make_pose(16'sd780, 16'sd760, 15'sd100));
        for (n = 0; n < 6; n++) pending_items.push_back(make_tick());
        for (n = 0; n < 10; n++) queue_random_pair(3000);
        drain();
        write_reg(CFG_GOAL_X, 16'sh7fff);
        for (n = 0; n < 5; n++) queue_random_pair(3000);
        drain();

        if (!failed) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
